/* rtl/mhpq_pkg.sv */
// shared types and codes for the min-heap priority queue
package mhpq_pkg;

  // operation codes of a request word
  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_UPDATE  = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  // status codes of a response word
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } stat_t;

  // read address selection
  typedef enum logic [2:0] {
    RD_ZERO,
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT,
    RD_IDX
  } rsel_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_EX_R0,
    S_EX_W0,
    S_EX_CHK,
    S_EX_WL,
    S_SR_ISS,
    S_SR_CMP,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_L,
    S_DN_R,
    S_DN_C,
    S_DN_D,
    S_FIN,
    S_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic  in_ready;
    logic  ins_start;
    logic  ex_take;
    logic  ex_key;
    logic  srch_clr;
    logic  srch_next;
    logic  srch_hit;
    logic  up_move;
    logic  place;
    logic  dn_left;
    logic  dn_right;
    logic  dn_move;
    logic  set_status;
    stat_t code;
    logic  rd_en;
    rsel_t rsel;
    logic  out_load;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       in_take;
    logic       full;
    logic       cnt_zero;
    logic       pos_zero;
    logic       key_lt_rd;
    logic       left_end;
    logic       right_ok;
    logic       rd_lt_pick;
    logic       pick_lt_key;
    logic       idx_end;
    logic       node_hit;
    logic       out_free;
  } sts_t;

endpackage

/* rtl/mhpq_if.sv */
// request and response channel interfaces of the min-heap priority queue
interface mhpq_req_if #(
  parameter int NODE_BITS = 16,
  parameter int DIST_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  logic [NODE_BITS-1:0] node_in;
  logic [DIST_BITS-1:0] dist_in;

  modport source (output valid, output cmd, output node_in, output dist_in, input ready);
  modport sink (input valid, input cmd, input node_in, input dist_in, output ready);
endinterface

interface mhpq_rsp_if #(
  parameter int NODE_BITS = 16,
  parameter int DIST_BITS = 32,
  parameter int CNT_BITS  = 9
);
  logic                 valid;
  logic                 ready;
  logic [NODE_BITS-1:0] node_out;
  logic [DIST_BITS-1:0] dist_out;
  logic [1:0]           status;
  logic [CNT_BITS-1:0]  entry_total;
  logic                 is_empty;

  modport source (output valid, output node_out, output dist_out, output status,
                  output entry_total, output is_empty, input ready);
  modport sink (input valid, input node_out, input dist_out, input status,
                input entry_total, input is_empty, output ready);
endinterface

/* rtl/min_heap_priority_queue.sv */
// top level of the min-heap priority queue with update key
//
//  channel  dir  fields                                         handshake
//  req      in   cmd, node_in, dist_in                          valid/ready
//  rsp      out  node_out, dist_out, status, entry_total,       valid/ready
//                is_empty
//
// one request word at a time; insert compares the key with each parent on its way up,
// extract takes the root and sifts the last entry down level by level, and update key
// scans the entries for the node and then sifts it; the steps are set by the
// single read port of the heap ram with its registered read.
// reset is synchronous and empties the heap at once; ram contents are left.
// a response waits in an output register; the next request is taken then,
// and the block only stalls at the end of that request if the response is
// still not taken.
module min_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY  = 256,
  parameter int NODE_BITS = 16,
  parameter int DIST_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  mhpq_req_if.sink   req,
  mhpq_rsp_if.source rsp
);

  ctl_t ctl;
  sts_t sts;

  mhpq_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .sts(sts),
    .ctl(ctl)
  );

  mhpq_dp #(
    .CAPACITY (CAPACITY),
    .NODE_BITS(NODE_BITS),
    .DIST_BITS(DIST_BITS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .ctl(ctl),
    .sts(sts)
  );

endmodule

/* rtl/mhpq_ram.sv */
// generic single-write single-read ram with registered read data
module mhpq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/mhpq_ctrl.sv */
// controller state machine of the min-heap priority queue
module mhpq_ctrl
  import mhpq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sts.in_take) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (sts.cmd)
          CMD_INSERT:  state_next = sts.full ? S_FIN : S_UP_CHK;
          CMD_EXTRACT: state_next = sts.cnt_zero ? S_FIN : S_EX_R0;
          CMD_UPDATE:  state_next = S_SR_ISS;
          default:     state_next = S_FIN;
        endcase
      end
      S_EX_R0:  state_next = S_EX_W0;
      S_EX_W0:  state_next = S_EX_CHK;
      S_EX_CHK: state_next = sts.cnt_zero ? S_FIN : S_EX_WL;
      S_EX_WL:  state_next = S_DN_L;
      S_SR_ISS: state_next = sts.idx_end ? S_FIN : S_SR_CMP;
      S_SR_CMP: begin
        if (!sts.node_hit) state_next = S_SR_ISS;
        else if (sts.key_lt_rd) state_next = S_UP_CHK;
        else state_next = S_DN_L;
      end
      S_UP_CHK: state_next = sts.pos_zero ? S_FIN : S_UP_CMP;
      S_UP_CMP: state_next = sts.key_lt_rd ? S_UP_CHK : S_FIN;
      S_DN_L:   state_next = sts.left_end ? S_FIN : S_DN_R;
      S_DN_R:   state_next = sts.right_ok ? S_DN_C : S_DN_D;
      S_DN_C:   state_next = S_DN_D;
      S_DN_D:   state_next = sts.pick_lt_key ? S_DN_L : S_FIN;
      S_FIN:    state_next = S_OUT;
      S_OUT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctl = '0;
    ctl.code = ST_OK;
    ctl.rsel = RD_ZERO;
    unique case (state)
      S_IDLE: ctl.in_ready = 1'b1;
      S_DISPATCH: begin
        unique case (sts.cmd)
          CMD_INSERT: begin
            ctl.ins_start  = !sts.full;
            ctl.set_status = sts.full;
            ctl.code       = ST_FULL;
          end
          CMD_EXTRACT: begin
            ctl.set_status = sts.cnt_zero;
            ctl.code       = ST_EMPTY;
          end
          CMD_UPDATE: ctl.srch_clr = 1'b1;
          default: ;
        endcase
      end
      S_EX_R0: begin
        ctl.rd_en = 1'b1;
        ctl.rsel  = RD_ZERO;
      end
      S_EX_W0: ctl.ex_take = 1'b1;
      S_EX_CHK: begin
        ctl.rd_en = 1'b1;
        ctl.rsel  = RD_LAST;
      end
      S_EX_WL: ctl.ex_key = 1'b1;
      S_SR_ISS: begin
        ctl.rd_en      = !sts.idx_end;
        ctl.rsel       = RD_IDX;
        ctl.set_status = sts.idx_end;
        ctl.code       = ST_MISSING;
      end
      S_SR_CMP: begin
        ctl.srch_next = !sts.node_hit;
        ctl.srch_hit  = sts.node_hit;
      end
      S_UP_CHK: begin
        ctl.place = sts.pos_zero;
        ctl.rd_en = !sts.pos_zero;
        ctl.rsel  = RD_PARENT;
      end
      S_UP_CMP: begin
        ctl.up_move = sts.key_lt_rd;
        ctl.place   = !sts.key_lt_rd;
      end
      S_DN_L: begin
        ctl.place = sts.left_end;
        ctl.rd_en = !sts.left_end;
        ctl.rsel  = RD_LEFT;
      end
      S_DN_R: begin
        ctl.dn_left = 1'b1;
        ctl.rd_en   = sts.right_ok;
        ctl.rsel    = RD_RIGHT;
      end
      S_DN_C: ctl.dn_right = sts.rd_lt_pick;
      S_DN_D: begin
        ctl.dn_move = sts.pick_lt_key;
        ctl.place   = !sts.pick_lt_key;
      end
      S_FIN: begin
        ctl.rd_en = 1'b1;
        ctl.rsel  = RD_ZERO;
      end
      S_OUT: ctl.out_load = sts.out_free;
      default: ;
    endcase
  end

  // a word is taken only while idle
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    sts.in_take |-> state == S_IDLE)
    else $error("word taken outside idle");

  // each taken word leads to dispatch
  a_take_dispatch: assert property (@(posedge clk) disable iff (rst)
    sts.in_take |=> state == S_DISPATCH)
    else $error("taken word not dispatched");

  // a response is loaded only when the output register is free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> sts.out_free)
    else $error("response loaded over a pending one");

endmodule

/* rtl/mhpq_dp.sv */
// datapath of the min-heap priority queue: heap ram, count, sift registers, output register
module mhpq_dp
  import mhpq_pkg::*;
#(
  parameter int CAPACITY  = 256,
  parameter int NODE_BITS = 16,
  parameter int DIST_BITS = 32
) (
  input  logic   clk,
  input  logic   rst,
  mhpq_req_if.sink   req,
  mhpq_rsp_if.source rsp,
  input  ctl_t   ctl,
  output sts_t   sts
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;
  localparam int EW = NODE_BITS + DIST_BITS;

  logic [1:0]           cmd_q;
  logic [NODE_BITS-1:0] key_node;
  logic [DIST_BITS-1:0] key_dist;
  logic [AW-1:0]        pos;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        idx;
  logic [AW-1:0]        pick;
  logic [NODE_BITS-1:0] pick_node;
  logic [DIST_BITS-1:0] pick_dist;
  logic [NODE_BITS-1:0] rn;
  logic [DIST_BITS-1:0] rd;
  logic                 taken;
  stat_t                status_q;

  logic                 out_valid;
  logic [NODE_BITS-1:0] out_node;
  logic [DIST_BITS-1:0] out_dist;
  logic [1:0]           out_status;
  logic [CW-1:0]        out_total;

  logic                 we;
  logic [AW-1:0]        raddr;
  logic [EW-1:0]        wdata;
  logic [EW-1:0]        rdata;
  logic [NODE_BITS-1:0] rd_node;
  logic [DIST_BITS-1:0] rd_dist;
  logic [XW-1:0]        left;
  logic [XW-1:0]        right;
  logic [XW-1:0]        cnt_x;
  logic [AW-1:0]        parent;
  logic [CW-1:0]        last;
  logic                 in_take;

  assign rd_node = rdata[EW-1:DIST_BITS];
  assign rd_dist = rdata[DIST_BITS-1:0];
  assign left    = {1'b0, pos, 1'b1};
  assign right   = left + XW'(1);
  assign cnt_x   = XW'(cnt);
  assign parent  = AW'((pos - AW'(1)) >> 1);
  assign last    = cnt;
  assign in_take = req.valid && ctl.in_ready;
  assign req.ready = ctl.in_ready;

  // status to the controller
  always_comb begin
    sts.cmd         = cmd_q;
    sts.in_take     = in_take;
    sts.full        = cnt >= CW'(CAPACITY);
    sts.cnt_zero    = cnt == '0;
    sts.pos_zero    = pos == '0;
    sts.key_lt_rd   = key_dist < rd_dist;
    sts.left_end    = left >= cnt_x;
    sts.right_ok    = right < cnt_x;
    sts.rd_lt_pick  = rd_dist < pick_dist;
    sts.pick_lt_key = pick_dist < key_dist;
    sts.idx_end     = idx >= cnt;
    sts.node_hit    = rd_node == key_node;
    sts.out_free    = !out_valid || rsp.ready;
  end

  // read address
  always_comb begin
    unique case (ctl.rsel)
      RD_ZERO:   raddr = '0;
      RD_LAST:   raddr = last[AW-1:0];
      RD_PARENT: raddr = parent;
      RD_LEFT:   raddr = left[AW-1:0];
      RD_RIGHT:  raddr = right[AW-1:0];
      RD_IDX:    raddr = idx[AW-1:0];
      default:   raddr = '0;
    endcase
  end

  // write data: parent moves down, child moves up, or the key lands
  always_comb begin
    we = ctl.up_move || ctl.place || ctl.dn_move;
    if (ctl.up_move) wdata = rdata;
    else if (ctl.dn_move) wdata = {pick_node, pick_dist};
    else wdata = {key_node, key_dist};
  end

  mhpq_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_heap (
    .clk  (clk),
    .we   (we),
    .waddr(pos),
    .wdata(wdata),
    .re   (ctl.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.ins_start) begin
      cnt <= cnt + CW'(1);
    end else if (ctl.ex_take) begin
      cnt <= cnt - CW'(1);
    end
  end

  // word capture, sift position and search index
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_q    <= req.cmd;
      key_node <= req.node_in;
      key_dist <= req.dist_in;
      taken    <= 1'b0;
      status_q <= ST_OK;
    end
    if (ctl.set_status) status_q <= ctl.code;
    if (ctl.ins_start) pos <= cnt[AW-1:0];
    if (ctl.ex_take) begin
      rn    <= rd_node;
      rd    <= rd_dist;
      taken <= 1'b1;
    end
    if (ctl.ex_key) begin
      key_node <= rd_node;
      key_dist <= rd_dist;
      pos      <= '0;
    end
    if (ctl.srch_clr) idx <= '0;
    if (ctl.srch_next) idx <= idx + CW'(1);
    if (ctl.srch_hit) pos <= idx[AW-1:0];
    if (ctl.up_move) pos <= parent;
    if (ctl.dn_left) begin
      pick      <= left[AW-1:0];
      pick_node <= rd_node;
      pick_dist <= rd_dist;
    end
    if (ctl.dn_right) begin
      pick      <= right[AW-1:0];
      pick_node <= rd_node;
      pick_dist <= rd_dist;
    end
    if (ctl.dn_move) pos <= pick;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status <= status_q;
      out_total  <= cnt;
      if (taken) begin
        out_node <= rn;
        out_dist <= rd;
      end else if (cnt != '0) begin
        out_node <= rd_node;
        out_dist <= rd_dist;
      end else begin
        out_node <= '0;
        out_dist <= '0;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.node_out    = out_node;
  assign rsp.dist_out    = out_dist;
  assign rsp.status      = out_status;
  assign rsp.entry_total = out_total;
  assign rsp.is_empty    = out_total == '0;

  // count stays within capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // heap writes only land inside the filled region
  a_write_in: assert property (@(posedge clk) disable iff (rst)
    we |-> CW'(pos) < cnt)
    else $error("heap write beyond count");

  // insert grows the count by one
  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    ctl.ins_start |=> cnt == $past(cnt) + CW'(1))
    else $error("insert did not grow count");

  // an empty-extract response reports no entries
  a_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_EMPTY |-> out_total == '0)
    else $error("empty status with entries held");

endmodule

/* tb/sv/tb_min_heap_priority_queue.sv */
// testbench for the min-heap priority queue: directed and random command streams checked against a behavioral heap
module tb_min_heap_priority_queue;
  import mhpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 256;
  localparam int CYCLE_LIMIT = 5000000;

  // one expected response word
  typedef struct {
    logic [15:0] node;
    logic [31:0] distance;
    stat_t       status;
    logic [8:0]  total;
    logic        empty;
  } heap_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mhpq_req_if #(.NODE_BITS(16), .DIST_BITS(32)) req ();
  mhpq_rsp_if #(.NODE_BITS(16), .DIST_BITS(32), .CNT_BITS(9)) rsp ();

  min_heap_priority_queue #(.CAPACITY(CAP), .NODE_BITS(16), .DIST_BITS(32)) dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // behavioral heap state
  logic [15:0] mdl_node [CAP];
  logic [31:0] mdl_dist [CAP];
  int          mdl_count;
  heap_rsp_t   pending_rsp [$];
  int          errors;
  int          words_sent;
  int          words_checked;
  int          cycles;
  bit          hold_rsp;
  logic [15:0] live_nodes [$];

  // place an entry moving toward the root
  function automatic void heap_rise(int pos, logic [15:0] n, logic [31:0] d);
    int up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!(d < mdl_dist[up])) break;
      mdl_node[pos] = mdl_node[up];
      mdl_dist[pos] = mdl_dist[up];
      pos = up;
    end
    mdl_node[pos] = n;
    mdl_dist[pos] = d;
  endfunction

  // place an entry moving toward the leaves
  function automatic void heap_sink(int pos, logic [15:0] n, logic [31:0] d);
    int lc;
    int pick;
    forever begin
      lc = 2 * pos + 1;
      if (lc >= mdl_count) break;
      pick = lc;
      if (lc + 1 < mdl_count && mdl_dist[lc + 1] < mdl_dist[lc]) pick = lc + 1;
      if (!(mdl_dist[pick] < d)) break;
      mdl_node[pos] = mdl_node[pick];
      mdl_dist[pos] = mdl_dist[pick];
      pos = pick;
    end
    mdl_node[pos] = n;
    mdl_dist[pos] = d;
  endfunction

  // apply one command to the heap and return the expected response
  function automatic heap_rsp_t heap_apply(logic [1:0] op, logic [15:0] n, logic [31:0] d);
    heap_rsp_t r;
    bit taken;
    int i;
    r.node = '0;
    r.distance = '0;
    r.status = ST_OK;
    taken = 1'b0;
    case (op)
      CMD_INSERT: begin
        if (mdl_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          mdl_count++;
          heap_rise(mdl_count - 1, n, d);
        end
      end
      CMD_EXTRACT: begin
        if (mdl_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.node = mdl_node[0];
          r.distance = mdl_dist[0];
          taken = 1'b1;
          mdl_count--;
          if (mdl_count > 0) heap_sink(0, mdl_node[mdl_count], mdl_dist[mdl_count]);
        end
      end
      CMD_UPDATE: begin
        i = 0;
        while (i < mdl_count && mdl_node[i] != n) i++;
        if (i >= mdl_count) r.status = ST_MISSING;
        else if (d < mdl_dist[i]) heap_rise(i, n, d);
        else heap_sink(i, n, d);
      end
      default: ;
    endcase
    if (!taken && mdl_count > 0) begin
      r.node = mdl_node[0];
      r.distance = mdl_dist[0];
    end
    r.total = mdl_count[8:0];
    r.empty = (mdl_count == 0);
    return r;
  endfunction

  // send one request word, after a random gap unless no_gap is set, and predict its response
  task automatic send_word(logic [1:0] op, logic [15:0] n, logic [31:0] d, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid   <= 1'b1;
    req.cmd     <= op;
    req.node_in <= n;
    req.dist_in <= d;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_rsp.push_back(heap_apply(op, n, d));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // node of some held entry, or a random one
  function automatic logic [15:0] pick_node();
    if (mdl_count > 0 && $urandom_range(0, 7) != 0) return mdl_node[$urandom_range(0, mdl_count - 1)];
    return 16'($urandom());
  endfunction

  // extremes of the fields, every command and each corner
  task automatic test_directed();
    send_word(CMD_EXTRACT, 16'h0000, 32'h0);
    send_word(CMD_UPDATE, 16'h1234, 32'h5);
    send_word(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(CMD_INSERT, 16'h0000, 32'h0000_0000);
    send_word(CMD_INSERT, 16'h5555, 32'h0000_0000);
    send_word(CMD_INSERT, 16'hAAAA, 32'h8000_0000);
    send_word(CMD_INSERT, 16'h0001, 32'h7FFF_FFFF);
    send_word(CMD_INSERT, 16'h0002, 32'h7FFF_FFFF);
    send_word(CMD_UPDATE, 16'hFFFF, 32'h0000_0001);
    send_word(CMD_UPDATE, 16'h0000, 32'hFFFF_FFFE);
    send_word(CMD_UPDATE, 16'h5555, 32'h0000_0000);
    send_word(CMD_UPDATE, 16'h0BAD, 32'h1);
    send_word(CMD_UNUSED, 16'h0, 32'h0);
    repeat (7) send_word(CMD_EXTRACT, 16'h0, 32'h0);
    wait_drained();
  endtask

  // fill to capacity, overflow, drain past empty; also the long sink stall
  task automatic test_fill_and_drain();
    fork
      begin
        hold_rsp = 1'b1;
        repeat (400) @(negedge clk);
        hold_rsp = 1'b0;
      end
    join_none
    for (int k = 0; k < CAP; k++) send_word(CMD_INSERT, 16'($urandom()), $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 15)) : $urandom(), 1);
    send_word(CMD_INSERT, 16'hBEEF, 32'h0);
    send_word(CMD_INSERT, 16'h0, 32'hFFFF_FFFF);
    for (int k = 0; k < 20; k++) send_word(CMD_UPDATE, pick_node(), $urandom());
    for (int k = 0; k < CAP + 2; k++) send_word(CMD_EXTRACT, 16'($urandom()), $urandom());
    wait_drained();
  endtask

  // random mix with mostly small heaps and repeated nodes and keys
  task automatic test_random_mix(int count);
    int sel;
    logic [31:0] d;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      d = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 31)) : $urandom();
      if (sel < 40 || mdl_count < 2 && sel < 60) send_word(CMD_INSERT, 16'($urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom()), d);
      else if (sel < 70) send_word(CMD_EXTRACT, 16'($urandom()), $urandom());
      else if (sel < 97) send_word(CMD_UPDATE, pick_node(), d);
      else send_word(CMD_UNUSED, 16'($urandom()), $urandom());
    end
    wait_drained();
  endtask

  // response sink with random stalls
  initial begin
    int stall;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0 || hold_rsp) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
        while (hold_rsp) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!(rsp.valid && rsp.ready)) @(posedge clk);
    end
  end

  // compare each accepted response word with the oldest prediction
  always @(posedge clk) begin
    heap_rsp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response word with no prediction pending");
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        words_checked++;
        if (rsp.node_out !== e.node) begin
          $error("node_out expected %0h actual %0h", e.node, rsp.node_out);
          errors++;
        end
        if (rsp.dist_out !== e.distance) begin
          $error("dist_out expected %0h actual %0h", e.distance, rsp.dist_out);
          errors++;
        end
        if (rsp.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, rsp.status);
          errors++;
        end
        if (rsp.entry_total !== e.total) begin
          $error("entry_total expected %0d actual %0d", e.total, rsp.entry_total);
          errors++;
        end
        if (rsp.is_empty !== e.empty) begin
          $error("is_empty expected %0b actual %0b", e.empty, rsp.is_empty);
          errors++;
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("min_heap_priority_queue test failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    cycles = 0;
    hold_rsp = 1'b0;
    mdl_count = 0;
    req.valid = 1'b0;
    req.cmd = CMD_INSERT;
    req.node_in = '0;
    req.dist_in = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_fill_and_drain();
    test_random_mix(850);
    if (pending_rsp.size() != 0) begin
      $error("%0d predicted responses never arrived", pending_rsp.size());
      errors++;
    end
    $display("run covered %0d request words and %0d checked responses", words_sent, words_checked);
    $display("including a full heap, overflow, extract past empty and key updates");
    if (errors == 0) begin
      $display("min_heap_priority_queue test passed");
    end else begin
      $display("min_heap_priority_queue test failed");
    end
    $finish;
  end

endmodule

/* min_heap_priority_queue.f */
rtl/mhpq_pkg.sv
rtl/mhpq_if.sv
rtl/mhpq_ram.sv
rtl/mhpq_ctrl.sv
rtl/mhpq_dp.sv
rtl/min_heap_priority_queue.sv
tb/sv/tb_min_heap_priority_queue.sv
